FILE: rtl/sbh_pkg.sv
// Shared types, constants and mixing functions for the byte stream hash.
`timescale 1ns / 1ps

package sbh_pkg;

    localparam int HASH_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic              first;   // first work unit of a message: seed the hash
        logic              empty;   // empty message, result is zero
        logic              group;   // data holds a full four-byte group
        logic              last;    // message ends with this unit
        logic [1:0]        rem;     // tail bytes left for the finish step
        logic [HASH_W-1:0] seed;    // message length, zero-extended
        logic [HASH_W-1:0] data;    // full group, or pending tail bytes
    } sbh_entry_t;

    function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
        return {{(HASH_W-8){b[7]}}, b};
    endfunction

    function automatic logic [HASH_W-1:0] mix_group(input logic [HASH_W-1:0] h,
                                                    input logic [HASH_W-1:0] w);
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] t;
        logic [HASH_W-1:0] h2;
        h1 = h + {16'd0, w[15:0]};
        t  = ({16'd0, w[31:16]} << 11) ^ h1;
        h2 = (h1 << 16) ^ t;
        return h2 + (h2 >> 11);
    endfunction

endpackage

FILE: rtl/sbh_front.sv
// Front end: tracks message position, gathers groups and issues work units.
`timescale 1ns / 1ps

module sbh_front #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          byte_value,
    input  logic [30:0]         message_length,
    input  logic                q_full,
    output logic                q_push,
    output sbh_pkg::sbh_entry_t q_entry
);
    import sbh_pkg::*;

    logic                   active_reg, active_next;
    logic                   seed_pend_reg, seed_pend_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] seen_reg, seen_next;
    logic [23:0]            pend_reg, pend_next;

    logic                   accept;
    logic [LENGTH_BITS-1:0] cur_len;
    logic [LENGTH_BITS-1:0] cur_seen;
    logic [LENGTH_BITS-1:0] new_seen;
    logic [23:0]            cur_pend;
    logic [23:0]            new_pend;
    logic                   cur_seed;
    logic                   is_empty;
    logic                   is_group;
    logic                   is_last;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    always_comb
    begin
        cur_len  = active_reg ? len_reg : message_length[LENGTH_BITS-1:0];
        cur_seen = active_reg ? seen_reg : '0;
        cur_pend = active_reg ? pend_reg : '0;
        cur_seed = active_reg ? seed_pend_reg : 1'b1;
        is_empty = !active_reg && (cur_len == '0);
        is_group = (cur_seen[1:0] == 2'd3);
        new_seen = cur_seen + 1'b1;
        is_last  = (new_seen == cur_len);

        case (cur_seen[1:0])
            2'd0:    new_pend = {16'd0, byte_value};
            2'd1:    new_pend = {8'd0, byte_value, cur_pend[7:0]};
            2'd2:    new_pend = {byte_value, cur_pend[15:0]};
            default: new_pend = '0;
        endcase

        q_push        = accept && (is_empty || is_group || is_last);
        q_entry.first = cur_seed;
        q_entry.empty = is_empty;
        q_entry.group = is_group && !is_empty;
        q_entry.last  = is_last && !is_empty;
        q_entry.rem   = new_seen[1:0];
        q_entry.seed  = {{(HASH_W-LENGTH_BITS){1'b0}}, cur_len};
        q_entry.data  = is_group ? {byte_value, cur_pend} : {8'd0, new_pend};

        active_next    = active_reg;
        seed_pend_next = seed_pend_reg;
        len_next       = len_reg;
        seen_next      = seen_reg;
        pend_next      = pend_reg;
        if (accept && !is_empty)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next    = 1'b1;
                seed_pend_next = cur_seed && !q_push;
                len_next       = cur_len;
                seen_next      = new_seen;
                pend_next      = new_pend;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            seed_pend_reg <= 1'b0;
            len_reg       <= '0;
            seen_reg      <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            seed_pend_reg <= seed_pend_next;
            len_reg       <= len_next;
            seen_reg      <= seen_next;
            pend_reg      <= pend_next;
        end
    end

endmodule

FILE: rtl/sbh_queue.sv
// Short work queue between the front end and the hash back end.
`timescale 1ns / 1ps

module sbh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sbh_pkg::sbh_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output sbh_pkg::sbh_entry_t pop_entry
);
    import sbh_pkg::*;

    sbh_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/sbh_back.sv
// Back end: group mixing into the running hash, then a pipelined finish.
`timescale 1ns / 1ps

module sbh_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_not_empty,
    input  sbh_pkg::sbh_entry_t         q_entry,
    output logic                        q_pop,
    output logic                        hash_valid,
    input  logic                        hash_stall,
    output logic [sbh_pkg::HASH_W-1:0]  hash_value
);
    import sbh_pkg::*;

    logic              adv;
    logic [HASH_W-1:0] h_in;
    logic [HASH_W-1:0] h_mix;
    logic              s0_fin;

    logic [HASH_W-1:0] run_hash_reg;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic [HASH_W-1:0] s1_h_reg, s2_h_reg, s3_h_reg, s4_h_reg, s5_h_reg;
    logic [1:0]        s1_rem_reg, s2_rem_reg;
    logic [23:0]       s1_pend_reg;
    logic              hash_valid_reg;
    logic [HASH_W-1:0] hash_value_reg;

    logic [HASH_W-1:0] s1_a;
    logic [HASH_W-1:0] s1_x;
    logic [HASH_W-1:0] s2_a;
    logic [HASH_W-1:0] s3_a;
    logic [HASH_W-1:0] s4_a;
    logic [HASH_W-1:0] s5_a;

    // The whole pipeline moves together whenever the output register can take a beat.
    assign adv   = !hash_valid_reg || !hash_stall;
    assign q_pop = adv && q_not_empty;

    always_comb
    begin
        h_in   = q_entry.first ? q_entry.seed : run_hash_reg;
        h_mix  = q_entry.group ? mix_group(h_in, q_entry.data) : h_in;
        s0_fin = q_entry.last || q_entry.empty;

        // Tail step, first half: add the tail word and spread it.
        case (s1_rem_reg)
            2'd3:
            begin
                s1_a = s1_h_reg + {16'd0, s1_pend_reg[15:0]};
                s1_x = s1_a ^ (s1_a << 16);
                s1_x = s1_x ^ (sext8(s1_pend_reg[23:16]) << 18);
            end
            2'd2:
            begin
                s1_a = s1_h_reg + {16'd0, s1_pend_reg[15:0]};
                s1_x = s1_a ^ (s1_a << 11);
            end
            2'd1:
            begin
                s1_a = s1_h_reg + sext8(s1_pend_reg[7:0]);
                s1_x = s1_a ^ (s1_a << 10);
            end
            default:
            begin
                s1_a = s1_h_reg;
                s1_x = s1_h_reg;
            end
        endcase

        case (s2_rem_reg)
            2'd3:    s2_a = s2_h_reg + (s2_h_reg >> 11);
            2'd2:    s2_a = s2_h_reg + (s2_h_reg >> 17);
            2'd1:    s2_a = s2_h_reg + (s2_h_reg >> 1);
            default: s2_a = s2_h_reg;
        endcase
        s2_a = s2_a ^ (s2_a << 3);

        s3_a = s3_h_reg + (s3_h_reg >> 5);
        s3_a = s3_a ^ (s3_a << 4);

        s4_a = s4_h_reg + (s4_h_reg >> 17);
        s4_a = s4_a ^ (s4_a << 25);

        s5_a = s5_h_reg + (s5_h_reg >> 6);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            hash_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (q_not_empty && !s0_fin)
            begin
                run_hash_reg <= h_mix;
            end
            s1_valid_reg   <= q_not_empty && s0_fin;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            s5_valid_reg   <= s4_valid_reg;
            hash_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // An empty message enters as zero, which the finish leaves at zero.
            s1_h_reg       <= q_entry.empty ? '0 : h_mix;
            s1_rem_reg     <= q_entry.empty ? 2'd0 : q_entry.rem;
            s1_pend_reg    <= q_entry.data[23:0];
            s2_h_reg       <= s1_x;
            s2_rem_reg     <= s1_rem_reg;
            s3_h_reg       <= s2_a;
            s4_h_reg       <= s3_a;
            s5_h_reg       <= s4_a;
            hash_value_reg <= s5_a;
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_value_reg;

endmodule

FILE: rtl/byte_stream_hash_32_top.sv
// The last unit passes the work queue, finish stages s1 to s5 and the output register.
// Throughput: one byte beat per cycle while the work queue is not full (byte_stall low).
// An empty message yields a zero hash along the same path.
// A stall on the hash output freezes the finish pipeline; the work queue holds four work units.
// Reset (rst_n low, asynchronous) drops any partial message and empties queue and pipeline.
`timescale 1ns / 1ps

module byte_stream_hash_32_top #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_stall,
    input  logic [7:0]                 byte_value,
    input  logic [30:0]                message_length,
    output logic                       hash_valid,
    input  logic                       hash_stall,
    output logic [sbh_pkg::HASH_W-1:0] hash_value
);
    import sbh_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    sbh_entry_t push_entry;
    sbh_entry_t pop_entry;

    sbh_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .byte_value     (byte_value),
        .message_length (message_length),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    sbh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_entry  (pop_entry)
    );

    sbh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .hash_valid  (hash_valid),
        .hash_stall  (hash_stall),
        .hash_value  (hash_value)
    );

endmodule
